// ===== rtl/core/iec_sds_pkg.sv =====
// Shared types, codes and constants for the IEC serial device side.
`default_nettype none

package iec_sds_pkg;

  // Default design constants
  localparam int BUF_DEPTH_DEF     = 32;
  localparam int PHASE_HOLD_DEF    = 5;
  localparam int EOI_IDLE_DEF      = 48;
  localparam int EOI_PULSE_DEF     = 8;
  localparam int TAKEOVER_HOLD_DEF = 8;

  // Register reset values
  localparam logic [4:0] DEVICE_NUMBER_RST = 5'd10;
  localparam logic [5:0] SEND_LENGTH_RST   = 6'd19;

  // Configuration port
  localparam int CFG_DATA_W = 6;
  localparam logic [0:0] REG_DEVICE_NUMBER = 1'b0;
  localparam logic [0:0] REG_SEND_LENGTH   = 1'b1;

  // Item function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;

  // Host port pin positions
  localparam int PIN_ATN  = 3;
  localparam int PIN_CLK  = 4;
  localparam int PIN_DATA = 5;

  // Command bytes
  localparam logic [7:0] CMD_LISTEN_BASE = 8'h20;
  localparam logic [7:0] CMD_UNLISTEN    = 8'h3F;
  localparam logic [7:0] CMD_TALK_BASE   = 8'h40;
  localparam logic [7:0] CMD_UNTALK      = 8'h5F;
  localparam logic [7:0] CMD_SECOND_MASK = 8'hF0;
  localparam logic [7:0] CMD_SECOND      = 8'h60;

  localparam logic [5:0] TX_POS_MAX = 6'd63;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_WAITREADY = 10'b00_0000_0010,
    ST_BITS      = 10'b00_0000_0100,
    ST_ACK       = 10'b00_0000_1000,
    ST_TURN      = 10'b00_0001_0000,
    ST_READY     = 10'b00_0010_0000,
    ST_EOIACK    = 10'b00_0100_0000,
    ST_SEND      = 10'b00_1000_0000,
    ST_ACKWAIT   = 10'b01_0000_0000,
    ST_UNTALKED  = 10'b10_0000_0000
  } bus_state_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] port_data;
    logic [4:0] buffer_index;
    logic [7:0] buffer_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] port_lines;
    logic [3:0] drive_state;
    logic [5:0] send_position;
  } result_t;

  // State number as seen by the host
  function automatic logic [3:0] state_num(input bus_state_t s);
    logic [3:0] n;
    unique case (s)
      ST_IDLE:      n = 4'd0;
      ST_WAITREADY: n = 4'd1;
      ST_BITS:      n = 4'd2;
      ST_ACK:       n = 4'd3;
      ST_TURN:      n = 4'd4;
      ST_READY:     n = 4'd5;
      ST_EOIACK:    n = 4'd6;
      ST_SEND:      n = 4'd7;
      ST_ACKWAIT:   n = 4'd8;
      ST_UNTALKED:  n = 4'd9;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

  // Directory listing held in the send buffer after reset
  function automatic logic [7:0] listing_byte(input logic [8:0] idx);
    logic [7:0] b;
    unique case (idx)
      9'd0:    b = 8'h01;
      9'd1:    b = 8'h04;
      9'd2:    b = 8'h10;
      9'd3:    b = 8'h04;
      9'd6:    b = 8'h22;
      9'd7:    b = 8'h46;
      9'd8:    b = 8'h41;
      9'd9:    b = 8'h4B;
      9'd10:   b = 8'h45;
      9'd11:   b = 8'h44;
      9'd12:   b = 8'h49;
      9'd13:   b = 8'h53;
      9'd14:   b = 8'h4B;
      9'd15:   b = 8'h22;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/iec_serial_device_side.sv =====
// IEC serial bus device side: protocol engine driven by host port accesses.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_ready     item   (func, port_data, index, byte)
//   result    out        result_valid / result_ready result (port_lines, drive_state, pos)
//   cfg       in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// An accepted item lands in an input register and is applied to the protocol
// state from there; a read item leaves its result in the output register at the
// same edge, so a read result passes the input register and then the output one.
// One item per cycle is sustained; the only limit is a read item meeting a full,
// unconsumed output register, which holds the input register.
// Synchronous reset restores the directory listing in the send buffer at once.
`default_nettype none

module iec_serial_device_side #(
  parameter int BUF_DEPTH     = iec_sds_pkg::BUF_DEPTH_DEF,
  parameter int PHASE_HOLD    = iec_sds_pkg::PHASE_HOLD_DEF,
  parameter int EOI_IDLE      = iec_sds_pkg::EOI_IDLE_DEF,
  parameter int EOI_PULSE     = iec_sds_pkg::EOI_PULSE_DEF,
  parameter int TAKEOVER_HOLD = iec_sds_pkg::TAKEOVER_HOLD_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               item_valid,
  output logic                              item_ready,
  input  wire iec_sds_pkg::item_t           item,
  output logic                              result_valid,
  input  wire                               result_ready,
  output iec_sds_pkg::result_t              result,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [0:0]                         cfg_index,
  input  wire [iec_sds_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Configuration registers
  logic [4:0] device_number;
  logic [5:0] send_length;

  // Input register
  logic                s1_valid;
  iec_sds_pkg::item_t  s1_item;
  logic                s1_go;
  logic                s1_read;

  // Send buffer
  logic [7:0] send_buffer [BUF_DEPTH];
  logic       buf_we;
  logic [8:0] buf_widx;

  // Protocol state
  iec_sds_pkg::bus_state_t bus_state, bus_state_next;
  logic [7:0] host_out, host_out_next;
  logic       drive_clk_pull, drive_clk_pull_next;
  logic       drive_data_pull, drive_data_pull_next;
  logic [7:0] shift_in, shift_in_next;
  logic [3:0] rx_bit_count, rx_bit_count_next;
  logic       atn_mode, atn_mode_next;
  logic       talking, talking_next;
  logic       listening, listening_next;
  logic       source_selected, source_selected_next;
  logic [5:0] tx_pos, tx_pos_next;
  logic [7:0] tx_byte, tx_byte_next;
  logic [3:0] tx_bit, tx_bit_next;
  logic       tx_phase, tx_phase_next;
  logic       eoi_pending, eoi_pending_next;
  logic       eoi_done, eoi_done_next;
  logic [2:0] phase_polls, phase_polls_next;
  logic [5:0] idle_polls, idle_polls_next;
  logic       eoi_ack_phase, eoi_ack_phase_next;
  logic [3:0] eoi_ack_polls, eoi_ack_polls_next;
  logic [3:0] takeover_polls, takeover_polls_next;
  logic       holding_takeover, holding_takeover_next;

  iec_sds_pkg::result_t result_next;

  assign cfg_ready  = 1'b1;
  assign s1_read    = (s1_item.func == iec_sds_pkg::FUNC_READ);
  assign s1_go      = s1_valid && (!s1_read || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_number <= iec_sds_pkg::DEVICE_NUMBER_RST;
      send_length   <= iec_sds_pkg::SEND_LENGTH_RST;
    end else if (cfg_valid) begin
      if (cfg_index == iec_sds_pkg::REG_DEVICE_NUMBER) begin
        device_number <= cfg_data[4:0];
      end else begin
        send_length <= cfg_data[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        send_buffer[i] <= iec_sds_pkg::listing_byte(9'(i));
      end
    end else if (buf_we) begin
      send_buffer[buf_widx[AW-1:0]] <= s1_item.buffer_byte;
    end
  end

  assign buf_widx = 9'(s1_item.buffer_index);
  assign buf_we   = s1_go && (s1_item.func == iec_sds_pkg::FUNC_LOAD) &&
                    (buf_widx < 9'(BUF_DEPTH));

  always_comb begin
    logic       clk_low;
    logic       clk_rise;
    logic       data_low;
    logic       atn_now;
    logic       atn_prev;
    logic [7:0] b;
    logic [5:0] eff_len;
    logic [8:0] pos_ext;
    logic [7:0] lines;

    bus_state_next        = bus_state;
    host_out_next         = host_out;
    drive_clk_pull_next   = drive_clk_pull;
    drive_data_pull_next  = drive_data_pull;
    shift_in_next         = shift_in;
    rx_bit_count_next     = rx_bit_count;
    atn_mode_next         = atn_mode;
    talking_next          = talking;
    listening_next        = listening;
    source_selected_next  = source_selected;
    tx_pos_next           = tx_pos;
    tx_byte_next          = tx_byte;
    tx_bit_next           = tx_bit;
    tx_phase_next         = tx_phase;
    eoi_pending_next      = eoi_pending;
    eoi_done_next         = eoi_done;
    phase_polls_next      = phase_polls;
    idle_polls_next       = idle_polls;
    eoi_ack_phase_next    = eoi_ack_phase;
    eoi_ack_polls_next    = eoi_ack_polls;
    takeover_polls_next   = takeover_polls;
    holding_takeover_next = holding_takeover;
    result_next           = '0;

    clk_low  = 1'b0;
    clk_rise = 1'b0;
    data_low = 1'b0;
    atn_now  = 1'b0;
    atn_prev = 1'b0;
    b        = 8'h00;
    eff_len  = 6'd0;
    pos_ext  = 9'd0;
    lines    = 8'h00;

    if (s1_go) begin
      unique case (s1_item.func)
        iec_sds_pkg::FUNC_WRITE: begin
          atn_now  = s1_item.port_data[iec_sds_pkg::PIN_ATN];
          atn_prev = host_out[iec_sds_pkg::PIN_ATN];
          host_out_next = s1_item.port_data;
          if (atn_now && !atn_prev) begin
            atn_mode_next        = 1'b1;
            drive_data_pull_next = 1'b1;
            drive_clk_pull_next  = 1'b0;
            bus_state_next       = iec_sds_pkg::ST_WAITREADY;
          end
          if (!atn_now && atn_prev) begin
            atn_mode_next = 1'b0;
            priority if (talking_next) begin
              bus_state_next = iec_sds_pkg::ST_TURN;
            end else if (listening_next) begin
              bus_state_next = iec_sds_pkg::ST_WAITREADY;
            end else begin
              drive_data_pull_next = 1'b0;
              bus_state_next       = iec_sds_pkg::ST_IDLE;
            end
          end

          // React to the new line levels
          clk_low  = host_out_next[iec_sds_pkg::PIN_CLK];
          clk_rise = !clk_low && host_out[iec_sds_pkg::PIN_CLK];
          data_low = host_out_next[iec_sds_pkg::PIN_DATA];
          eff_len  = source_selected_next ? send_length : 6'd0;
          unique case (bus_state_next)
            iec_sds_pkg::ST_WAITREADY: begin
              if (clk_rise) begin
                drive_data_pull_next = 1'b0;
                shift_in_next        = 8'h00;
                rx_bit_count_next    = 4'd0;
                bus_state_next       = iec_sds_pkg::ST_BITS;
              end
            end
            iec_sds_pkg::ST_BITS: begin
              if (clk_rise) begin
                shift_in_next     = {!data_low, shift_in_next[7:1]};
                rx_bit_count_next = rx_bit_count_next + 4'd1;
                if (rx_bit_count_next == 4'd8) begin
                  drive_data_pull_next = 1'b1;
                  bus_state_next       = iec_sds_pkg::ST_ACK;
                  b = shift_in_next;
                  // Decode the command byte; LISTEN and TALK win over their undo codes
                  if (atn_mode_next) begin
                    priority if (b == 8'(iec_sds_pkg::CMD_LISTEN_BASE + 8'(device_number))) begin
                      listening_next = 1'b1;
                    end else if (b == iec_sds_pkg::CMD_UNLISTEN) begin
                      listening_next = 1'b0;
                    end else if (b == 8'(iec_sds_pkg::CMD_TALK_BASE + 8'(device_number))) begin
                      talking_next = 1'b1;
                    end else if (b == iec_sds_pkg::CMD_UNTALK) begin
                      talking_next         = 1'b0;
                      drive_clk_pull_next  = 1'b0;
                      drive_data_pull_next = 1'b0;
                      bus_state_next       = iec_sds_pkg::ST_UNTALKED;
                    end else if ((b & iec_sds_pkg::CMD_SECOND_MASK) == iec_sds_pkg::CMD_SECOND &&
                                 talking_next) begin
                      source_selected_next = 1'b1;
                      tx_pos_next          = 6'd0;
                    end else begin
                    end
                  end
                end
              end
            end
            iec_sds_pkg::ST_ACK: begin
              if (clk_low) begin
                bus_state_next = (atn_mode_next || listening_next) ?
                                 iec_sds_pkg::ST_WAITREADY : iec_sds_pkg::ST_IDLE;
              end
            end
            iec_sds_pkg::ST_TURN: begin
              if (data_low && !clk_low) begin
                drive_data_pull_next  = 1'b0;
                drive_clk_pull_next   = 1'b1;
                takeover_polls_next   = 4'd0;
                holding_takeover_next = 1'b1;
                pos_ext = 9'(tx_pos_next);
                tx_byte_next = (!source_selected_next || pos_ext >= 9'(BUF_DEPTH)) ?
                               8'h00 : send_buffer[pos_ext[AW-1:0]];
                eoi_pending_next = ({1'b0, tx_pos_next} + 7'd1) >= {1'b0, eff_len};
                eoi_done_next    = 1'b0;
                bus_state_next   = iec_sds_pkg::ST_READY;
              end
            end
            iec_sds_pkg::ST_READY: begin
              if (!data_low) begin
                if (eoi_pending_next && !eoi_done_next) begin
                  bus_state_next      = iec_sds_pkg::ST_EOIACK;
                  drive_clk_pull_next = 1'b0;
                end else begin
                  bus_state_next      = iec_sds_pkg::ST_SEND;
                  tx_bit_next         = 4'd0;
                  tx_phase_next       = 1'b0;
                  phase_polls_next    = 3'd0;
                  drive_clk_pull_next = 1'b1;
                end
              end
            end
            iec_sds_pkg::ST_EOIACK: begin
              if (data_low) begin
                eoi_done_next = 1'b1;
              end else if (eoi_done_next) begin
                bus_state_next      = iec_sds_pkg::ST_SEND;
                tx_bit_next         = 4'd0;
                tx_phase_next       = 1'b0;
                phase_polls_next    = 3'd0;
                drive_clk_pull_next = 1'b1;
              end
            end
            iec_sds_pkg::ST_ACKWAIT: begin
              if (data_low) begin
                if (tx_pos_next >= eff_len) begin
                  drive_clk_pull_next  = 1'b0;
                  drive_data_pull_next = 1'b0;
                  bus_state_next       = iec_sds_pkg::ST_IDLE;
                end else begin
                  pos_ext = 9'(tx_pos_next);
                  tx_byte_next = (!source_selected_next || pos_ext >= 9'(BUF_DEPTH)) ?
                                 8'h00 : send_buffer[pos_ext[AW-1:0]];
                  eoi_pending_next    = ({1'b0, tx_pos_next} + 7'd1) >= {1'b0, eff_len};
                  eoi_done_next       = 1'b0;
                  bus_state_next      = iec_sds_pkg::ST_READY;
                  drive_clk_pull_next = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end

        iec_sds_pkg::FUNC_READ: begin
          if (holding_takeover) begin
            if (takeover_polls >= 4'(TAKEOVER_HOLD)) begin
              holding_takeover_next = 1'b0;
              drive_clk_pull_next   = 1'b0;
            end else begin
              takeover_polls_next = takeover_polls + 4'd1;
            end
          end

          // Talker: advance one half-phase every PHASE_HOLD polls
          if (bus_state == iec_sds_pkg::ST_SEND) begin
            phase_polls_next = phase_polls + 3'd1;
            if (phase_polls_next >= 3'(PHASE_HOLD)) begin
              phase_polls_next = 3'd0;
              if (!tx_phase) begin
                drive_data_pull_next = !tx_byte[tx_bit[2:0]];
                drive_clk_pull_next  = 1'b0;
                tx_phase_next        = 1'b1;
              end else begin
                drive_clk_pull_next  = 1'b1;
                drive_data_pull_next = 1'b0;
                tx_phase_next        = 1'b0;
                tx_bit_next          = tx_bit + 4'd1;
                if (tx_bit_next == 4'd8) begin
                  if (tx_pos < iec_sds_pkg::TX_POS_MAX) begin
                    tx_pos_next = tx_pos + 6'd1;
                  end
                  bus_state_next = iec_sds_pkg::ST_ACKWAIT;
                end
              end
            end
          end

          // Listener: acknowledge an end-of-item wait by a short DATA pulse
          if (bus_state_next != iec_sds_pkg::ST_BITS || rx_bit_count != 4'd0 ||
              host_out[iec_sds_pkg::PIN_CLK]) begin
            idle_polls_next = 6'd0;
          end else if (eoi_ack_phase) begin
            if (eoi_ack_polls >= 4'(EOI_PULSE)) begin
              drive_data_pull_next = 1'b0;
              eoi_ack_phase_next   = 1'b0;
            end else begin
              eoi_ack_polls_next = eoi_ack_polls + 4'd1;
            end
          end else if (idle_polls >= 6'(EOI_IDLE)) begin
            drive_data_pull_next = 1'b1;
            eoi_ack_phase_next   = 1'b1;
            eoi_ack_polls_next   = 4'd0;
            idle_polls_next      = 6'd0;
          end else begin
            idle_polls_next = idle_polls + 6'd1;
          end

          lines = {2'b00, host_out[5:0]};
          lines[6] = !(host_out[iec_sds_pkg::PIN_CLK] || drive_clk_pull_next);
          lines[7] = !(host_out[iec_sds_pkg::PIN_DATA] || drive_data_pull_next);
          result_next.port_lines    = lines;
          result_next.drive_state   = iec_sds_pkg::state_num(bus_state_next);
          result_next.send_position = tx_pos_next;
        end

        default: begin
          // Buffer loads go through the write port; the spare code does nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_state        <= iec_sds_pkg::ST_IDLE;
      host_out         <= 8'h00;
      drive_clk_pull   <= 1'b0;
      drive_data_pull  <= 1'b0;
      shift_in         <= 8'h00;
      rx_bit_count     <= 4'd0;
      atn_mode         <= 1'b0;
      talking          <= 1'b0;
      listening        <= 1'b0;
      source_selected  <= 1'b0;
      tx_pos           <= 6'd0;
      tx_byte          <= 8'h00;
      tx_bit           <= 4'd0;
      tx_phase         <= 1'b0;
      eoi_pending      <= 1'b0;
      eoi_done         <= 1'b0;
      phase_polls      <= 3'd0;
      idle_polls       <= 6'd0;
      eoi_ack_phase    <= 1'b0;
      eoi_ack_polls    <= 4'd0;
      takeover_polls   <= 4'd0;
      holding_takeover <= 1'b0;
    end else begin
      bus_state        <= bus_state_next;
      host_out         <= host_out_next;
      drive_clk_pull   <= drive_clk_pull_next;
      drive_data_pull  <= drive_data_pull_next;
      shift_in         <= shift_in_next;
      rx_bit_count     <= rx_bit_count_next;
      atn_mode         <= atn_mode_next;
      talking          <= talking_next;
      listening        <= listening_next;
      source_selected  <= source_selected_next;
      tx_pos           <= tx_pos_next;
      tx_byte          <= tx_byte_next;
      tx_bit           <= tx_bit_next;
      tx_phase         <= tx_phase_next;
      eoi_pending      <= eoi_pending_next;
      eoi_done         <= eoi_done_next;
      phase_polls      <= phase_polls_next;
      idle_polls       <= idle_polls_next;
      eoi_ack_phase    <= eoi_ack_phase_next;
      eoi_ack_polls    <= eoi_ack_polls_next;
      takeover_polls   <= takeover_polls_next;
      holding_takeover <= holding_takeover_next;
    end
  end

  // Output register: load on a read item, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_read) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_read) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_item))
    else $error("input register changed while held");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_read |=> result_valid)
    else $error("read item produced no result");

  a_tx_bit: assert property (@(posedge clk) disable iff (rst)
    bus_state == iec_sds_pkg::ST_SEND |-> tx_bit < 4'd8)
    else $error("bit counter past end of byte while sending");

  a_rx_bit: assert property (@(posedge clk) disable iff (rst)
    rx_bit_count <= 4'd8)
    else $error("receive bit counter overrun");

  a_takeover: assert property (@(posedge clk) disable iff (rst)
    holding_takeover |-> takeover_polls <= 4'(TAKEOVER_HOLD))
    else $error("takeover hold counter overrun");
`endif

endmodule

`default_nettype wire

// ===== verif/iec_sds_tb_pkg.sv =====
// Scoreboard for the IEC serial device side: port-level protocol predictor and read checker.
package iec_sds_tb_pkg;
  import iec_sds_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;

  localparam logic [7:0] ATN_LOW  = 8'h01 << PIN_ATN;
  localparam logic [7:0] CLK_LOW  = 8'h01 << PIN_CLK;
  localparam logic [7:0] DATA_LOW = 8'h01 << PIN_DATA;

  localparam int LISTING_BYTES = 19;
  localparam logic [8*LISTING_BYTES-1:0] DIR_LISTING =
    152'h0104_1004_0000_2246_414B_4544_4953_4B22_0000_00;

  typedef enum logic [3:0] {
    BP_IDLE, BP_WAITREADY, BP_BITS, BP_ACK, BP_TURN,
    BP_READY, BP_EOIACK, BP_SEND, BP_ACKWAIT, BP_UNTALKED
  } bus_phase_e;

  class bus_port_scoreboard;
    logic [4:0] dev_num;
    logic [5:0] send_len;
    bus_phase_e phase;
    logic [7:0] host_out, shift_in, tx_byte;
    int unsigned rx_bits, tx_pos, tx_bit, phase_polls, idle_polls;
    int unsigned eoi_ack_polls, takeover_polls;
    bit pull_clk, pull_data, atn_mode, talking, listening, src_sel;
    bit tx_half, eoi_pending, eoi_done, eoi_ack_phase, hold_takeover;
    logic [7:0] send_buf [BUF_DEPTH_DEF];
    result_t reads_due [$];
    int unsigned errors;

    function new();
      dev_num = DEVICE_NUMBER_RST;
      send_len = SEND_LENGTH_RST;
      phase = BP_IDLE;
      host_out = '0; shift_in = '0; tx_byte = '0;
      rx_bits = 0; tx_pos = 0; tx_bit = 0; phase_polls = 0; idle_polls = 0;
      eoi_ack_polls = 0; takeover_polls = 0;
      pull_clk = 0; pull_data = 0; atn_mode = 0; talking = 0; listening = 0; src_sel = 0;
      tx_half = 0; eoi_pending = 0; eoi_done = 0; eoi_ack_phase = 0; hold_takeover = 0;
      errors = 0;
      foreach (send_buf[i])
        send_buf[i] = (i < LISTING_BYTES) ? DIR_LISTING[8*LISTING_BYTES-1-8*i -: 8] : 8'h00;
    endfunction

    function void write_reg(input logic [0:0] idx, input logic [5:0] val);
      if (idx == REG_DEVICE_NUMBER) dev_num = val[4:0];
      else send_len = val;
    endfunction

    function int unsigned eff_len();
      return src_sel ? int'(send_len) : 0;
    endfunction

    function void load_tx();
      tx_byte = (src_sel && tx_pos < BUF_DEPTH_DEF) ? send_buf[tx_pos] : 8'h00;
      eoi_pending = (tx_pos + 1 >= eff_len());
      eoi_done = 0;
      phase = BP_READY;
    endfunction

    function void start_bits();
      phase = BP_SEND;
      tx_bit = 0;
      tx_half = 0;
      phase_polls = 0;
      pull_clk = 1;
    endfunction

    function void decode_command();
      logic [7:0] listen_cmd, talk_cmd;
      listen_cmd = CMD_LISTEN_BASE + 8'(dev_num);
      talk_cmd = CMD_TALK_BASE + 8'(dev_num);
      if (!atn_mode) return;
      // own address wins over the fixed codes
      if (shift_in == listen_cmd) listening = 1;
      else if (shift_in == CMD_UNLISTEN) listening = 0;
      else if (shift_in == talk_cmd) talking = 1;
      else if (shift_in == CMD_UNTALK) begin
        talking = 0;
        pull_clk = 0;
        pull_data = 0;
        phase = BP_UNTALKED;
      end else if ((shift_in & CMD_SECOND_MASK) == CMD_SECOND && talking) begin
        src_sel = 1;
        tx_pos = 0;
      end
    endfunction

    function void react(input logic [7:0] prev);
      bit clk_low, clk_rise, data_low;
      clk_low = host_out[PIN_CLK];
      clk_rise = !clk_low && prev[PIN_CLK];
      data_low = host_out[PIN_DATA];
      case (phase)
        BP_WAITREADY: if (clk_rise) begin
          pull_data = 0;
          shift_in = '0;
          rx_bits = 0;
          phase = BP_BITS;
        end
        BP_BITS: if (clk_rise) begin
          shift_in = {~data_low, shift_in[7:1]};
          rx_bits++;
          if (rx_bits == 8) begin
            pull_data = 1;
            phase = BP_ACK;
            decode_command();
          end
        end
        BP_ACK: if (clk_low) begin
          phase = (atn_mode || listening) ? BP_WAITREADY : BP_IDLE;
        end
        BP_TURN: if (data_low && !clk_low) begin
          pull_data = 0;
          pull_clk = 1;
          takeover_polls = 0;
          load_tx();
          hold_takeover = 1;
        end
        BP_READY: if (!data_low) begin
          if (eoi_pending && !eoi_done) begin
            phase = BP_EOIACK;
            pull_clk = 0;
          end else start_bits();
        end
        BP_EOIACK: begin
          if (data_low) eoi_done = 1;
          else if (eoi_done) start_bits();
        end
        BP_ACKWAIT: if (data_low) begin
          if (tx_pos >= eff_len()) begin
            pull_clk = 0;
            pull_data = 0;
            phase = BP_IDLE;
          end else begin
            load_tx();
            pull_clk = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void host_write(input logic [7:0] v);
      logic [7:0] prev;
      bit atn, atn_prev;
      prev = host_out;
      atn = v[PIN_ATN];
      atn_prev = prev[PIN_ATN];
      host_out = v;
      if (atn && !atn_prev) begin
        atn_mode = 1;
        pull_data = 1;
        pull_clk = 0;
        phase = BP_WAITREADY;
      end
      if (!atn && atn_prev) begin
        atn_mode = 0;
        if (talking) phase = BP_TURN;
        else if (listening) phase = BP_WAITREADY;
        else begin
          pull_data = 0;
          phase = BP_IDLE;
        end
      end
      react(prev);
    endfunction

    function void poll_talker();
      if (phase != BP_SEND) return;
      phase_polls++;
      if (phase_polls < PHASE_HOLD_DEF) return;
      phase_polls = 0;
      if (!tx_half) begin
        pull_data = !tx_byte[tx_bit % 8];
        pull_clk = 0;
        tx_half = 1;
      end else begin
        pull_clk = 1;
        pull_data = 0;
        tx_half = 0;
        tx_bit++;
        if (tx_bit == 8) begin
          if (tx_pos < TX_POS_MAX) tx_pos++;
          phase = BP_ACKWAIT;
        end
      end
    endfunction

    function void poll_listener();
      if (phase != BP_BITS || rx_bits != 0 || host_out[PIN_CLK]) begin
        idle_polls = 0;
        return;
      end
      if (eoi_ack_phase) begin
        if (eoi_ack_polls >= EOI_PULSE_DEF) begin
          pull_data = 0;
          eoi_ack_phase = 0;
        end else eoi_ack_polls++;
        return;
      end
      // long CLK-high pause before the first bit means EOI: pulse DATA
      if (idle_polls >= EOI_IDLE_DEF) begin
        pull_data = 1;
        eoi_ack_phase = 1;
        eoi_ack_polls = 0;
        idle_polls = 0;
      end else idle_polls++;
    endfunction

    function result_t read_lines();
      result_t r;
      if (hold_takeover) begin
        if (takeover_polls >= TAKEOVER_HOLD_DEF) begin
          hold_takeover = 0;
          pull_clk = 0;
        end else takeover_polls++;
      end
      poll_talker();
      poll_listener();
      r.port_lines = {~(host_out[PIN_DATA] | pull_data), ~(host_out[PIN_CLK] | pull_clk),
                      host_out[5:0]};
      r.drive_state = phase;
      r.send_position = 6'(tx_pos);
      return r;
    endfunction

    function void apply_access(input item_t it);
      case (it.func)
        FUNC_WRITE: host_write(it.port_data);
        FUNC_LOAD: if (it.buffer_index < BUF_DEPTH_DEF) send_buf[it.buffer_index] = it.buffer_byte;
        FUNC_READ: reads_due.push_back(read_lines());
        default: ;
      endcase
    endfunction

    function void check_read(input result_t got);
      result_t want;
      if (reads_due.size() == 0) begin
        $error("result with no read pending: %h", got);
        errors++;
        return;
      end
      want = reads_due.pop_front();
      if (got.port_lines !== want.port_lines) begin
        $error("port_lines: expected %h, got %h", want.port_lines, got.port_lines);
        errors++;
      end
      if (got.drive_state !== want.drive_state) begin
        $error("drive_state: expected %0d, got %0d", want.drive_state, got.drive_state);
        errors++;
      end
      if (got.send_position !== want.send_position) begin
        $error("send_position: expected %0d, got %0d", want.send_position, got.send_position);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== verif/iec_serial_device_side_tb.sv =====
// Testbench top for the IEC serial device side: host-side protocol stimulus and read checks.
module iec_serial_device_side_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iec_sds_pkg::*;
  import iec_sds_tb_pkg::*;

  typedef enum {LEAD_NONE, LEAD_UNSOURCED, LEAD_SOURCED} lead_e;

  localparam int QUIET_LIMIT = 400;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bus_port_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int items_sent = 0;
  int quiet = 0;

  iec_serial_device_side uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: stall at random, then check each read result
  initial begin : read_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = gaps_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_read(result);
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.func = 2'($urandom_range(0, 3));
    it.port_data = 8'($urandom);
    it.buffer_index = 5'($urandom);
    it.buffer_byte = 8'($urandom);
    return it;
  endfunction

  // Random host bits outside ATN, CLK and DATA
  function automatic logic [7:0] stray_bits();
    return 8'($urandom) & 8'hC7;
  endfunction

  function automatic logic [7:0] listen_cmd();
    return CMD_LISTEN_BASE + 8'(sb.dev_num);
  endfunction

  function automatic logic [7:0] talk_cmd();
    return CMD_TALK_BASE + 8'(sb.dev_num);
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 9))
      0, 1, 2: return listen_cmd();
      3: return CMD_UNLISTEN;
      4, 5: return talk_cmd();
      6: return CMD_UNTALK;
      7: return CMD_SECOND | 8'($urandom_range(0, 15));
      8: return 8'($urandom_range(8'h20, 8'h5F));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push(input item_t it);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    sb.apply_access(it);
    items_sent++;
  endtask

  task automatic poke(input logic [7:0] v);
    item_t it;
    it = random_item();
    it.func = FUNC_WRITE;
    it.port_data = v;
    push(it);
  endtask

  task automatic peek_n(input int n);
    item_t it;
    repeat (n) begin
      it = random_item();
      it.func = FUNC_READ;
      push(it);
    end
  endtask

  task automatic stash(input logic [4:0] idx, input logic [7:0] b);
    item_t it;
    it = random_item();
    it.func = FUNC_LOAD;
    it.buffer_index = idx;
    it.buffer_byte = b;
    push(it);
  endtask

  task automatic maybe_peek();
    if ($urandom_range(0, 3) == 0) peek_n($urandom_range(1, 3));
  endtask

  task automatic set_registers(input logic [5:0] dev_val, input logic [5:0] len_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEVICE_NUMBER;
    cfg_data <= dev_val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_DEVICE_NUMBER, dev_val);
    cfg_index <= REG_SEND_LENGTH;
    cfg_data <= len_val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_SEND_LENGTH, len_val);
    cfg_valid <= 1'b0;
  endtask

  // Hold off until every read has come back and the last write has landed
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.reads_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Clock one byte in, LSB first; fewer than 8 bits leaves a broken byte
  task automatic send_byte(input logic [7:0] b, input bit atn, input int nbits);
    logic [7:0] a;
    logic [7:0] d;
    a = atn ? ATN_LOW : 8'h00;
    poke(a | CLK_LOW | stray_bits());
    maybe_peek();
    poke(a | stray_bits());
    // a long pause here trips the listener EOI handshake
    if ($urandom_range(0, 6) == 0) peek_n($urandom_range(50, 62));
    for (int i = 0; i < nbits; i++) begin
      d = b[i] ? 8'h00 : DATA_LOW;
      poke(a | CLK_LOW | d | stray_bits());
      poke(a | d | stray_bits());
      maybe_peek();
    end
  endtask

  task automatic release_bus();
    poke(stray_bits());
  endtask

  // Act as listener for the device's talk data until it lets go
  task automatic take_listing();
    int guard;
    guard = 0;
    while (guard < 8000 &&
           sb.phase inside {BP_TURN, BP_READY, BP_EOIACK, BP_SEND, BP_ACKWAIT}) begin
      guard++;
      if (sb.phase != BP_SEND && $urandom_range(0, 2) == 0) peek_n($urandom_range(1, 4));
      if ($urandom_range(0, 99) == 0) break;
      case (sb.phase)
        BP_TURN: poke(DATA_LOW | stray_bits());
        BP_READY: poke(stray_bits());
        BP_EOIACK: poke(sb.eoi_done ? stray_bits() : (DATA_LOW | stray_bits()));
        BP_SEND: peek_n(1);
        BP_ACKWAIT: poke(DATA_LOW | stray_bits());
        default: ;
      endcase
    end
  endtask

  task automatic talk_session(input bit sourced);
    release_bus();
    if ($urandom_range(0, 3) == 0) send_byte(CMD_UNLISTEN, 1'b1, 8);
    send_byte(talk_cmd(), 1'b1, 8);
    if (sourced) send_byte(CMD_SECOND | 8'($urandom_range(0, 15)), 1'b1, 8);
    release_bus();
    take_listing();
    if ($urandom_range(0, 1) == 0) begin
      release_bus();
      send_byte(CMD_UNTALK, 1'b1, 8);
      release_bus();
    end
  endtask

  task automatic listen_session();
    release_bus();
    send_byte(listen_cmd(), 1'b1, 8);
    if ($urandom_range(0, 1) == 0) send_byte(CMD_SECOND | 8'($urandom_range(0, 15)), 1'b1, 8);
    release_bus();
    repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 8);
    release_bus();
    send_byte(CMD_UNLISTEN, 1'b1, 8);
    release_bus();
  endtask

  task automatic random_exchange();
    int kind;
    kind = $urandom_range(0, 99);
    gaps_on = ($urandom_range(0, 3) != 0);
    if (kind < 40) begin
      talk_session($urandom_range(0, 9) != 0);
    end else if (kind < 55) begin
      listen_session();
    end else if (kind < 70) begin
      release_bus();
      repeat ($urandom_range(1, 3))
        send_byte(pick_command(), 1'b1, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 8);
      release_bus();
      if (sb.phase == BP_TURN && $urandom_range(0, 1) == 0) take_listing();
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 4)) stash(5'($urandom), 8'($urandom));
      maybe_peek();
    end else begin
      repeat ($urandom_range(1, 8)) push(random_item());
    end
  endtask

  task automatic run_phase(input bit reconfigure, input logic [5:0] dev_val,
                           input logic [5:0] len_val, input lead_e lead, input int n);
    int target;
    if (reconfigure) begin
      settle();
      set_registers(dev_val, len_val);
    end
    target = items_sent + n;
    if (lead != LEAD_NONE) talk_session(lead == LEAD_SOURCED);
    while (items_sent < target) random_exchange();
  endtask

  task automatic directed_items();
    item_t it;
    peek_n(1);
    stash(5'd0, 8'hFF);
    stash(5'd31, 8'h00);
    stash(5'd31, 8'hFF);
    it = '1;
    push(it);
    it = '0;
    it.func = FUNC_NONE;
    push(it);
    poke(8'hFF);
    peek_n(1);
    poke(8'h00);
    peek_n(1);
    it = '1;
    it.func = FUNC_READ;
    push(it);
    it = '0;
    push(it);
    it = '1;
    it.func = FUNC_WRITE;
    push(it);
    peek_n(1);
    it = '0;
    it.func = FUNC_WRITE;
    push(it);
    peek_n(2);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    // reset values, first talk with no source selected
    run_phase(1'b0, '0, '0, LEAD_UNSOURCED, 60);
    // device 31 turns the unlisten and untalk codes into its own addresses
    run_phase(1'b1, 6'd31, 6'd1, LEAD_SOURCED, 60);
    run_phase(1'b1, 6'd0, 6'd0, LEAD_SOURCED, 60);
    run_phase(1'b1, 6'd30, 6'd32, LEAD_SOURCED, 60);
    // upper data bit drops for the device register; long send runs past the buffer
    run_phase(1'b1, 6'h2A, 6'd63, LEAD_SOURCED, 60);
    run_phase(1'b1, 6'($urandom_range(0, 31)), 6'($urandom_range(0, 4)),
              lead_e'($urandom_range(0, 2)), 60);

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
